>>> rtl/rqcf_pkg.sv
// ----------------------------------------------------------------------------
// rqcf_pkg
// Shared types, field widths and the error probability ROM of the read
// quality crop filter.
// ----------------------------------------------------------------------------
package rqcf_pkg;

  // Field widths
  localparam int QUAL_W     = 8;
  localparam int Q_W        = 7;
  localparam int TABLE_SIZE = 128;
  localparam int LEN_W      = 20;
  localparam int TAIL_W     = 7;
  localparam int PROB_W     = 33;
  localparam int SUM_W      = 52;
  localparam int CFG_W      = 33;
  localparam int CFG_IDX_W  = 2;
  // head crop plus tail crop, tail crop never above 127
  localparam int CROP_W     = LEN_W + 1;

  localparam logic [QUAL_W-1:0] PHRED_OFFSET = 8'd33;
  localparam logic [PROB_W-1:0] PROB_ONE     = 33'h1_0000_0000;

  // Register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAD_CROP      = 2'd0,
    CFG_TAIL_CROP      = 2'd1,
    CFG_MIN_LENGTH     = 2'd2,
    CFG_MAX_ERROR_PROB = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [LEN_W-1:0]  head_crop;
    logic [TAIL_W-1:0] tail_crop;
    logic [LEN_W-1:0]  min_length;
    logic [PROB_W-1:0] max_error_prob;
  } cfg_t;

  // One base held in the input register
  typedef struct packed {
    logic           valid;
    logic           last;
    logic           has_q;
    logic [Q_W-1:0] q;
    logic [Q_W-1:0] old_q;  // score leaving the tail delay line
  } beat_t;

  // Per-read sums captured at the last base
  typedef struct packed {
    logic             valid;
    logic             has_q;
    logic [SUM_W-1:0] total;
    logic [SUM_W-1:0] middle;
  } read_sum_t;

  typedef logic [PROB_W-1:0] rom_t [TABLE_SIZE];

  // 10^(-k/10) scaled by 10^16
  localparam logic [63:0] DEC16 = 64'd10000000000000000;
  localparam logic [63:0] TENTH_POW [10] = '{
    64'd10000000000000000, 64'd7943282347242815, 64'd6309573444801932,
    64'd5011872336272722,  64'd3981071705534972, 64'd3162277660168379,
    64'd2511886431509580,  64'd1995262314968880, 64'd1584893192461113,
    64'd1258925411794167
  };

  // Q1.32 error probability per Phred score, built at elaboration.
  // q = 10*m + k; V = floor(C[k] * 2^40 / 10^16); entry = V / 2^8 / 10^m
  // rounded half up, zero from m = 10 on.
  function automatic rom_t build_err_rom();
    rom_t        rom;
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] pw;
    logic [63:0] x;
    int          m;
    int          k;
    for (int q = 0; q < TABLE_SIZE; q++) begin
      m = q / 10;
      k = q % 10;
      if (m >= 10) begin
        rom[q] = '0;
      end else begin
        c = TENTH_POW[k];
        v = (c / DEC16) << 40;
        r = c % DEC16;
        for (int b = 39; b >= 0; b--) begin
          r = r << 1;
          if (r >= DEC16) begin
            r = r - DEC16;
            v[b] = 1'b1;
          end
        end
        pw = 64'd1;
        for (int i = 0; i < m; i++) begin
          pw = pw * 64'd10;
        end
        // nested floor divisions equal one floor division by 256 * 10^m
        x = (v + (pw << 7)) >> 8;
        for (int i = 0; i < m; i++) begin
          x = x / 64'd10;
        end
        rom[q] = x[PROB_W-1:0];
      end
    end
    return rom;
  endfunction

  localparam rom_t ERR_ROM = build_err_rom();

  // Saturating accumulate of one probability
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0]  a,
                                                input logic [PROB_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(b);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

>>> rtl/rqcf_if.sv
// ----------------------------------------------------------------------------
// rqcf_if
// Valid/ready channels of the read quality crop filter: the base stream and
// the per-read verdict stream.
// ----------------------------------------------------------------------------
interface rqcf_in_if import rqcf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [QUAL_W-1:0] qual_char;
  logic              has_quality;
  logic              last_base;

  modport source(output valid, qual_char, has_quality, last_base, input ready);
  modport sink(input valid, qual_char, has_quality, last_base, output ready);
endinterface

interface rqcf_out_if import rqcf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             passed;
  logic [LEN_W-1:0] read_length;
  logic [LEN_W-1:0] cropped_length;
  logic [SUM_W-1:0] total_error_sum;
  logic [SUM_W-1:0] cropped_error_sum;

  modport source(output valid, passed, read_length, cropped_length, total_error_sum,
                 cropped_error_sum, input ready);
  modport sink(input valid, passed, read_length, cropped_length, total_error_sum,
               cropped_error_sum, output ready);
endinterface

>>> rtl/rqcf_front.sv
// ----------------------------------------------------------------------------
// rqcf_front
// Input register: converts the quality character to a clamped Phred score
// and runs the tail delay line, a circular memory read tail_len beats back.
// ----------------------------------------------------------------------------
module rqcf_front import rqcf_pkg::*; #(
  parameter int  MAX_TAIL_CROP = 64,
  localparam int TW            = $clog2(MAX_TAIL_CROP + 1)
) (
  input  logic          clk,
  input  logic          rst,
  rqcf_in_if.sink       bases,
  input  logic [TW-1:0] tail_len,
  input  logic          take,    // held beat leaves the input register
  output beat_t         beat
);

  localparam int PTR_W = (MAX_TAIL_CROP > 1) ? $clog2(MAX_TAIL_CROP) : 1;
  localparam int XW    = $clog2(2 * MAX_TAIL_CROP + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_TAIL_CROP - 1);

  logic [Q_W-1:0]    delay_mem [MAX_TAIL_CROP];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  slot;
  logic [XW-1:0]     slot_wide;
  logic [QUAL_W-1:0] q_full;
  logic [Q_W-1:0]    q_in;
  logic              accept;

  assign bases.ready = !beat.valid || take;
  assign accept      = bases.valid && bases.ready;

  // Phred score, clamped to the table
  always_comb begin
    q_full = bases.qual_char - PHRED_OFFSET;
    if (bases.qual_char < PHRED_OFFSET) begin
      q_in = '0;
    end else if (q_full > QUAL_W'(TABLE_SIZE - 1)) begin
      q_in = Q_W'(TABLE_SIZE - 1);
    end else begin
      q_in = q_full[Q_W-1:0];
    end
  end

  // Slot written tail_len beats ago
  always_comb begin
    slot_wide = XW'(wr_ptr) + XW'(MAX_TAIL_CROP) - XW'(tail_len);
    if (slot_wide >= XW'(MAX_TAIL_CROP)) begin
      slot_wide = slot_wide - XW'(MAX_TAIL_CROP);
    end
    slot = PTR_W'(slot_wide);
  end

  // Write pointer restarts with every read and wraps after the last slot
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
    end else if (accept) begin
      if (bases.last_base || wr_ptr == PTR_LAST) begin
        wr_ptr <= '0;
      end else begin
        wr_ptr <= wr_ptr + 1'b1;
      end
    end
  end

  // Delay line: old entry read before the new score lands
  always_ff @(posedge clk) begin
    if (accept) begin
      delay_mem[wr_ptr] <= q_in;
      beat.old_q        <= delay_mem[slot];
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
    end else if (accept) begin
      beat.valid <= 1'b1;
    end else if (take) begin
      beat.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      beat.last  <= bases.last_base;
      beat.has_q <= bases.has_quality;
      beat.q     <= q_in;
    end
  end

endmodule

>>> rtl/rqcf_accum.sv
// ----------------------------------------------------------------------------
// rqcf_accum
// Per-read state: base position and the two saturating error sums. At the
// last base the totals move into a capture register and the state clears.
// ----------------------------------------------------------------------------
module rqcf_accum import rqcf_pkg::*; #(
  parameter int LENGTH_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  beat_t                  beat,
  input  logic [CROP_W-1:0]      crop_total,
  input  logic                   has_tail,
  input  logic                   room,        // capture register can load
  output logic                   take,
  output read_sum_t              rsum,
  output logic [LENGTH_BITS-1:0] len
);

  localparam int CW = (LENGTH_BITS > CROP_W) ? LENGTH_BITS : CROP_W;

  logic [LENGTH_BITS-1:0] position;
  logic [LENGTH_BITS-1:0] position_next;
  logic [SUM_W-1:0]       total_sum;
  logic [SUM_W-1:0]       total_next;
  logic [SUM_W-1:0]       middle_sum;
  logic [SUM_W-1:0]       middle_next;
  logic [PROB_W-1:0]      mid_add;
  logic                   in_middle;
  logic                   fire;

  // a last base waits until the capture register is free
  assign take = !beat.last || room;
  assign fire = beat.valid && take;

  // Middle takes the base leaving the delay line, or the new one without tail
  assign mid_add   = has_tail ? ERR_ROM[beat.old_q] : ERR_ROM[beat.q];
  assign in_middle = CW'(position) >= CW'(crop_total);

  always_comb begin
    total_next    = sat_add(total_sum, ERR_ROM[beat.q]);
    middle_next   = in_middle ? sat_add(middle_sum, mid_add) : middle_sum;
    position_next = (&position) ? position : position + 1'b1;
  end

  // Read state
  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      total_sum  <= '0;
      middle_sum <= '0;
    end else if (fire) begin
      if (beat.last) begin
        position   <= '0;
        total_sum  <= '0;
        middle_sum <= '0;
      end else begin
        position   <= position_next;
        total_sum  <= total_next;
        middle_sum <= middle_next;
      end
    end
  end

  // Capture register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsum.valid <= 1'b0;
    end else if (room) begin
      rsum.valid <= fire && beat.last;
    end
  end

  always_ff @(posedge clk) begin
    if (room && fire && beat.last) begin
      rsum.has_q  <= beat.has_q;
      rsum.total  <= total_next;
      rsum.middle <= middle_next;
      len         <= position_next;
    end
  end

endmodule

>>> rtl/rqcf_judge.sv
// ----------------------------------------------------------------------------
// rqcf_judge
// Verdict pipeline: cropped length, threshold product, pass decision and the
// output register.
// ----------------------------------------------------------------------------
module rqcf_judge import rqcf_pkg::*; #(
  parameter int LENGTH_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic [CROP_W-1:0]      crop_total,
  input  read_sum_t              rsum,
  input  logic [LENGTH_BITS-1:0] len,
  output logic                   room,
  rqcf_out_if.source             verdicts
);

  localparam int DW   = (LENGTH_BITS > CROP_W) ? LENGTH_BITS : CROP_W;
  localparam int MXW  = (LENGTH_BITS > LEN_W) ? LENGTH_BITS : LEN_W;
  localparam int PFW  = LENGTH_BITS + PROB_W;
  localparam int PW   = (PFW > 64) ? 64 : PFW;
  localparam int CMPW = (PW > SUM_W) ? PW : SUM_W;

  logic                   go_out;
  logic                   go_prod;

  // crop stage
  logic                   crop_valid;
  logic                   crop_has_q;
  logic [LENGTH_BITS-1:0] crop_len;
  logic [LENGTH_BITS-1:0] crop_clen;
  logic [SUM_W-1:0]       crop_total_sum;
  logic [SUM_W-1:0]       crop_middle_sum;
  logic [DW-1:0]          clen_diff;
  logic [LENGTH_BITS-1:0] clen_calc;

  // product stage
  logic                   prod_valid;
  logic                   prod_has_q;
  logic                   prod_len_ok;
  logic [LENGTH_BITS-1:0] prod_len;
  logic [LENGTH_BITS-1:0] prod_clen;
  logic [SUM_W-1:0]       prod_total_sum;
  logic [SUM_W-1:0]       prod_middle_sum;
  logic [PW-1:0]          prod_limit;
  logic [PFW-1:0]         limit_full;
  logic [LEN_W-1:0]       min_len;

  // output register
  logic                   out_valid;
  logic                   out_passed;
  logic [LEN_W-1:0]       out_len;
  logic [LEN_W-1:0]       out_clen;
  logic [SUM_W-1:0]       out_total;
  logic [SUM_W-1:0]       out_middle;
  logic                   too_noisy;

  // Stage enables, each register loads when empty or draining
  assign go_out  = !out_valid || verdicts.ready;
  assign go_prod = !prod_valid || go_out;
  assign room    = !crop_valid || go_prod;

  // Cropped length, zero when the crop exceeds the read
  always_comb begin
    clen_diff = DW'(len) - DW'(crop_total);
    clen_calc = (DW'(len) > DW'(crop_total)) ? LENGTH_BITS'(clen_diff) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crop_valid <= 1'b0;
    end else if (room) begin
      crop_valid <= rsum.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (room && rsum.valid) begin
      crop_has_q      <= rsum.has_q;
      crop_len        <= len;
      crop_clen       <= clen_calc;
      crop_total_sum  <= rsum.total;
      crop_middle_sum <= rsum.middle;
    end
  end

  // Threshold: cropped length times the mean error limit
  assign min_len    = (cfg.min_length == '0) ? LEN_W'(1) : cfg.min_length;
  assign limit_full = PFW'(crop_clen) * PFW'(cfg.max_error_prob);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (go_prod) begin
      prod_valid <= crop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go_prod && crop_valid) begin
      prod_has_q      <= crop_has_q;
      prod_len_ok     <= MXW'(crop_clen) >= MXW'(min_len);
      prod_len        <= crop_len;
      prod_clen       <= crop_clen;
      prod_total_sum  <= crop_total_sum;
      prod_middle_sum <= crop_middle_sum;
      prod_limit      <= limit_full[PW-1:0];
    end
  end

  // Pass decision into the output register
  assign too_noisy = prod_has_q && (CMPW'(prod_middle_sum) > CMPW'(prod_limit));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go_out) begin
      out_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go_out && prod_valid) begin
      out_passed <= prod_len_ok && !too_noisy;
      out_len    <= LEN_W'(prod_len);
      out_clen   <= LEN_W'(prod_clen);
      out_total  <= prod_has_q ? prod_total_sum : '0;
      out_middle <= prod_has_q ? prod_middle_sum : '0;
    end
  end

  assign verdicts.valid             = out_valid;
  assign verdicts.passed            = out_passed;
  assign verdicts.read_length       = out_len;
  assign verdicts.cropped_length    = out_clen;
  assign verdicts.total_error_sum   = out_total;
  assign verdicts.cropped_error_sum = out_middle;

endmodule

>>> rtl/read_quality_crop_filter.sv
// Verdict path: input, capture, crop and product registers, then the output register.
// Throughput: one base per cycle unless a last base waits for the capture register;
// the ROM lookup and saturating add of each position and sum update act on the held beat.
// Output stalls back up through four verdict stages; bases that are not last keep flowing.
// Reset (rst, synchronous): read state and pipeline valids clear, registers
// return to no crop, minimum length one, error limit 1.0; delay line stays.
// ----------------------------------------------------------------------------
// read_quality_crop_filter
// Per-read mean error and length filter with head and tail crop.
// ----------------------------------------------------------------------------
module read_quality_crop_filter import rqcf_pkg::*; #(
  parameter int MAX_TAIL_CROP = 64,
  parameter int LENGTH_BITS   = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  rqcf_in_if.sink              bases,
  rqcf_out_if.source           verdicts,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int TW = $clog2(MAX_TAIL_CROP + 1);

  cfg_t                   cfg;
  logic [TW-1:0]          tail_len;
  logic [CROP_W-1:0]      crop_total;
  logic                   take;
  logic                   room;
  beat_t                  beat;
  read_sum_t              rsum;
  logic [LENGTH_BITS-1:0] len;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.head_crop      <= '0;
      cfg.tail_crop      <= '0;
      cfg.min_length     <= LEN_W'(1);
      cfg.max_error_prob <= PROB_ONE;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_HEAD_CROP:      cfg.head_crop      <= cfg_data[LEN_W-1:0];
        CFG_TAIL_CROP:      cfg.tail_crop      <= cfg_data[TAIL_W-1:0];
        CFG_MIN_LENGTH:     cfg.min_length     <= cfg_data[LEN_W-1:0];
        CFG_MAX_ERROR_PROB: cfg.max_error_prob <= cfg_data[PROB_W-1:0];
      endcase
    end
  end

  // Tail crop limited to the delay line depth
  always_comb begin
    if (32'(cfg.tail_crop) > MAX_TAIL_CROP) begin
      tail_len = TW'(MAX_TAIL_CROP);
    end else begin
      tail_len = TW'(cfg.tail_crop);
    end
    crop_total = CROP_W'(cfg.head_crop) + CROP_W'(tail_len);
  end

  rqcf_front #(
    .MAX_TAIL_CROP(MAX_TAIL_CROP)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .bases    (bases),
    .tail_len (tail_len),
    .take     (take),
    .beat     (beat)
  );

  rqcf_accum #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .beat       (beat),
    .crop_total (crop_total),
    .has_tail   (tail_len != '0),
    .room       (room),
    .take       (take),
    .rsum       (rsum),
    .len        (len)
  );

  rqcf_judge #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_judge (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .crop_total (crop_total),
    .rsum       (rsum),
    .len        (len),
    .room       (room),
    .verdicts   (verdicts)
  );

endmodule

>>> rtl/rqcf_checker.sv
// ----------------------------------------------------------------------------
// rqcf_checker
// Port-level checks of the read quality crop filter, bound to the top level.
// ----------------------------------------------------------------------------
module rqcf_checker import rqcf_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             passed,
  input logic [LEN_W-1:0] read_length,
  input logic [LEN_W-1:0] cropped_length,
  input logic [SUM_W-1:0] total_error_sum,
  input logic [SUM_W-1:0] cropped_error_sum
);

  // A stalled verdict beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(passed) && $stable(read_length) &&
      $stable(cropped_length) && $stable(total_error_sum) && $stable(cropped_error_sum))
    else $error("verdict beat changed while stalled");

  // Reset leaves the verdict output empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("verdict valid after reset");

  // With the output register empty nothing can block the base stream
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("bases stalled with an empty output");

  // Cropping never lengthens a read
  a_crop_shorter: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cropped_length <= read_length)
    else $error("cropped length above read length");

endmodule

bind read_quality_crop_filter rqcf_checker u_rqcf_checker (
  .clk               (clk),
  .rst               (rst),
  .in_ready          (bases.ready),
  .out_valid         (verdicts.valid),
  .out_ready         (verdicts.ready),
  .passed            (verdicts.passed),
  .read_length       (verdicts.read_length),
  .cropped_length    (verdicts.cropped_length),
  .total_error_sum   (verdicts.total_error_sum),
  .cropped_error_sum (verdicts.cropped_error_sum)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the read quality crop filter. Bases are streamed as
// whole reads with random gaps on the input and random stalls on the verdict
// side. A local predictor keeps its own error table, sums and tail ring, and
// every verdict beat is compared field by field against it.
// ----------------------------------------------------------------------------
module tb_top;
  import rqcf_pkg::*;

  localparam int RING_DEPTH = 64;
  localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;
  localparam longint unsigned LEN_LIMIT = (64'd1 << LEN_W) - 64'd1;

  typedef struct packed {
    logic             passed;
    logic [LEN_W-1:0] read_length;
    logic [LEN_W-1:0] cropped_length;
    logic [SUM_W-1:0] total_error_sum;
    logic [SUM_W-1:0] cropped_error_sum;
  } verdict_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  cfg_index_t            cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  rqcf_in_if  base_ch ();
  rqcf_out_if verdict_ch ();

  read_quality_crop_filter DUT (
    .clk      (clk),
    .rst      (rst),
    .bases    (base_ch),
    .verdicts (verdict_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 10^(-k/10) scaled by 10^16, one per tenth of a decade
  localparam logic [63:0] DECADE_STEP [10] = '{
    64'd10000000000000000, 64'd7943282347242815, 64'd6309573444801932,
    64'd5011872336272722,  64'd3981071705534972, 64'd3162277660168379,
    64'd2511886431509580,  64'd1995262314968880, 64'd1584893192461113,
    64'd1258925411794167
  };

  // Predictor state and register copy
  logic [PROB_W-1:0] err_prob [TABLE_SIZE];
  logic [LEN_W-1:0]  cfg_head;
  logic [TAIL_W-1:0] cfg_tail;
  logic [LEN_W-1:0]  cfg_min;
  logic [PROB_W-1:0] cfg_maxp;
  logic [LEN_W-1:0]  run_pos;
  logic [SUM_W-1:0]  run_total;
  logic [SUM_W-1:0]  run_middle;
  logic [5:0]        ring_ptr;
  logic [Q_W-1:0]    ring [RING_DEPTH];

  verdict_t pending_verdicts [$];

  bit      idle_on;
  int      stall_left = 0;
  int      stall_len;
  longint  bases_sent;
  int      reads_sent;
  int      verdicts_checked;
  int      config_count;
  int      mismatches;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("read_quality_crop_filter regression: fail");
    $finish;
  end

  // Error table: V = floor(C * 2^40 / 10^16), entry = V / (256 * 10^m) rounded half up
  function automatic logic [PROB_W-1:0] err_entry(int q);
    logic [127:0] v;
    logic [127:0] div;
    if (q >= 100) return '0;
    div = 128'd256;
    for (int i = 0; i < q / 10; i++) div = div * 128'd10;
    v = ({64'd0, DECADE_STEP[q % 10]} << 40) / 128'd10000000000000000;
    return PROB_W'((v + (div >> 1)) / div);
  endfunction

  function automatic logic [SUM_W-1:0] add_sat(logic [SUM_W-1:0] a, logic [PROB_W-1:0] b);
    longint unsigned s;
    s = longint'(a) + longint'(b);
    return (s > SUM_LIMIT) ? SUM_W'(SUM_LIMIT) : SUM_W'(s);
  endfunction

  // Advance the predictor by one accepted base; queue a verdict on the last one
  function automatic void predict_base(logic [QUAL_W-1:0] ch, logic hq, logic lb);
    logic [Q_W-1:0]  q;
    logic [Q_W-1:0]  oq;
    int              t;
    longint unsigned p;
    longint unsigned crop;
    longint unsigned clen;
    longint unsigned minl;
    verdict_t        v;
    q = (ch < 8'd33) ? 7'd0 : (ch > 8'd160) ? 7'd127 : Q_W'(ch - 8'd33);
    t = (cfg_tail > 7'd64) ? 64 : int'(cfg_tail);
    p = run_pos;
    run_total = add_sat(run_total, err_prob[q]);
    if (t == 0) begin
      if (p >= cfg_head) run_middle = add_sat(run_middle, err_prob[q]);
    end else if (p >= t) begin
      // base leaving the tail window joins the middle
      oq = ring[6'(ring_ptr - t)];
      if (p - t >= cfg_head) run_middle = add_sat(run_middle, err_prob[oq]);
    end
    ring[ring_ptr] = q;
    ring_ptr = ring_ptr + 6'd1;
    if (run_pos != LEN_W'(LEN_LIMIT)) run_pos = run_pos + 1'b1;
    if (!lb) return;

    crop = longint'(cfg_head) + t;
    clen = (longint'(run_pos) > crop) ? longint'(run_pos) - crop : 0;
    minl = (cfg_min == '0) ? 1 : longint'(cfg_min);
    v.passed = 1'b1;
    if (clen < minl) v.passed = 1'b0;
    else if (hq && longint'(run_middle) > clen * longint'(cfg_maxp)) v.passed = 1'b0;
    v.read_length       = run_pos;
    v.cropped_length    = LEN_W'(clen);
    v.total_error_sum   = hq ? run_total : '0;
    v.cropped_error_sum = hq ? run_middle : '0;
    pending_verdicts.push_back(v);
    run_pos    = '0;
    run_total  = '0;
    run_middle = '0;
    ring_ptr   = '0;
  endfunction

  // Gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [QUAL_W-1:0] pick_char(int mode);
    case (mode)
      0:       return QUAL_W'(33 + $urandom_range(0, 45));
      1:       return QUAL_W'($urandom_range(0, 40));
      2:       return QUAL_W'($urandom_range(150, 255));
      default: return QUAL_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 12);
    if (r < 95) return $urandom_range(13, 80);
    return $urandom_range(81, 140);
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH verdict %0d %s: got 0x%0h, expected 0x%0h",
             verdicts_checked, what, got, want);
    mismatches++;
  endtask

  task automatic check_verdict();
    verdict_t w;
    if (pending_verdicts.size() == 0) begin
      report_mismatch("beat with nothing pending", verdict_ch.read_length, 0);
      return;
    end
    w = pending_verdicts.pop_front();
    if (verdict_ch.passed !== w.passed)
      report_mismatch("passed", verdict_ch.passed, w.passed);
    if (verdict_ch.read_length !== w.read_length)
      report_mismatch("read_length", verdict_ch.read_length, w.read_length);
    if (verdict_ch.cropped_length !== w.cropped_length)
      report_mismatch("cropped_length", verdict_ch.cropped_length, w.cropped_length);
    if (verdict_ch.total_error_sum !== w.total_error_sum)
      report_mismatch("total_error_sum", verdict_ch.total_error_sum, w.total_error_sum);
    if (verdict_ch.cropped_error_sum !== w.cropped_error_sum)
      report_mismatch("cropped_error_sum", verdict_ch.cropped_error_sum, w.cropped_error_sum);
    verdicts_checked++;
  endtask

  // Verdict sink: check accepted beats, then pick the next ready value
  always @(posedge clk) begin
    if (!rst && verdict_ch.valid && verdict_ch.ready) check_verdict();
    if (stall_left != 0) begin
      verdict_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      stall_len = pick_gap();
      if (stall_len == 0) begin
        verdict_ch.ready <= 1'b1;
      end else begin
        verdict_ch.ready <= 1'b0;
        stall_left <= stall_len - 1;
      end
    end
  end

  // One base beat, held until accepted
  task automatic send_base(logic [QUAL_W-1:0] ch, logic hq, logic lb);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      base_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    base_ch.valid       <= 1'b1;
    base_ch.qual_char   <= ch;
    base_ch.has_quality <= hq;
    base_ch.last_base   <= lb;
    do @(posedge clk); while (!base_ch.ready);
    predict_base(ch, hq, lb);
    bases_sent++;
  endtask

  // One read; with noise the flag on non-last bases is random
  task automatic send_read(int len, int mode, logic hq, bit noise);
    logic h;
    for (int i = 0; i < len; i++) begin
      h = (noise && i != len - 1) ? logic'($urandom_range(0, 1)) : hq;
      send_base(pick_char(mode), h, i == len - 1);
    end
    reads_sent++;
  endtask

  // Wait for all verdicts, then let the pipeline empty
  task automatic settle();
    base_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // All four registers, one per cycle, only while idle
  task automatic write_config(logic [LEN_W-1:0] head, logic [TAIL_W-1:0] tail,
                              logic [LEN_W-1:0] minl, logic [PROB_W-1:0] maxp);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HEAD_CROP;
    cfg_data  <= CFG_W'(head);
    @(posedge clk);
    cfg_head  = head;
    cfg_index <= CFG_TAIL_CROP;
    cfg_data  <= CFG_W'(tail);
    @(posedge clk);
    cfg_tail  = tail;
    cfg_index <= CFG_MIN_LENGTH;
    cfg_data  <= CFG_W'(minl);
    @(posedge clk);
    cfg_min   = minl;
    cfg_index <= CFG_MAX_ERROR_PROB;
    cfg_data  <= CFG_W'(maxp);
    @(posedge clk);
    cfg_maxp  = maxp;
    cfg_we    <= 1'b0;
    config_count++;
  endtask

  task automatic rand_config();
    logic [LEN_W-1:0]  h;
    logic [TAIL_W-1:0] t;
    logic [LEN_W-1:0]  m;
    logic [PROB_W-1:0] p;
    case ($urandom_range(0, 4))
      0:       h = '0;
      1, 2:    h = LEN_W'($urandom_range(0, 10));
      3:       h = LEN_W'($urandom_range(0, 60));
      default: h = LEN_W'($urandom_range(0, 1048575));
    endcase
    case ($urandom_range(0, 3))
      0:       t = '0;
      1:       t = TAIL_W'(64);
      2:       t = TAIL_W'($urandom_range(1, 8));
      default: t = TAIL_W'($urandom_range(0, 64));
    endcase
    case ($urandom_range(0, 4))
      0:       m = '0;
      1:       m = LEN_W'(1);
      2:       m = LEN_W'($urandom_range(1, 20));
      3:       m = '1;
      default: m = LEN_W'($urandom_range(1, 60));
    endcase
    case ($urandom_range(0, 3))
      0:       p = '0;
      1:       p = PROB_ONE;
      2: begin
        p = {1'($urandom_range(0, 1)), 32'($urandom())};
        if (p > PROB_ONE) p = PROB_ONE;
      end
      default: p = err_prob[$urandom_range(3, 35)];
    endcase
    write_config(h, t, m, p);
  endtask

  // Single-base reads across the score clamp points, then a read without qualities
  task automatic test_score_clamp();
    logic [QUAL_W-1:0] chars [8] = '{8'd0, 8'd32, 8'd33, 8'd34, 8'd126, 8'd160, 8'd161, 8'd255};
    idle_on = 1'b1;
    foreach (chars[i]) begin
      send_base(chars[i], 1'b1, 1'b1);
      reads_sent++;
    end
    send_base(8'd70, 1'b0, 1'b0);
    send_base(8'd0, 1'b0, 1'b0);
    send_base(8'd255, 1'b0, 1'b1);
    reads_sent++;
  endtask

  // Small head and tail crop, then a crop that swallows the whole read
  task automatic test_crop_edges();
    logic [QUAL_W-1:0] chars [8] = '{8'd0, 8'd40, 8'd255, 8'd33, 8'd60, 8'd10, 8'd75, 8'd161};
    write_config(LEN_W'(2), TAIL_W'(3), LEN_W'(2), err_prob[20]);
    foreach (chars[i]) send_base(chars[i], 1'b1, i == 7);
    reads_sent++;
    write_config('1, TAIL_W'(64), '1, '0);
    send_read(4, 0, 1'b1, 1'b0);
  endtask

  // Register extremes, each with a handful of reads
  task automatic test_config_extremes();
    write_config('0, TAIL_W'(64), '0, PROB_ONE);
    send_read(66, 0, 1'b1, 1'b0);
    repeat (2) send_read(pick_len(), $urandom_range(0, 3), 1'b1, 1'b1);
    write_config('0, TAIL_W'(1), LEN_W'(1), '0);
    repeat (2) send_read(pick_len(), $urandom_range(0, 3), 1'($urandom_range(0, 1)), 1'b0);
    write_config('1, '0, LEN_W'(1), PROB_ONE);
    repeat (2) send_read(pick_len(), $urandom_range(0, 3), 1'b1, 1'b0);
    write_config(LEN_W'(5), TAIL_W'(64), '1, err_prob[10]);
    send_read(68, 0, 1'b1, 1'b0);
    send_read(pick_len(), 1, 1'b1, 1'b0);
    write_config('0, '0, LEN_W'(1), err_prob[30]);
    repeat (2) send_read(pick_len(), $urandom_range(0, 3), 1'b1, 1'b1);
  endtask

  // Random registers per phase, random reads; every third phase without idling
  task automatic test_random_reads();
    longint start;
    logic   hq;
    for (int phase = 0; phase < 8; phase++) begin
      rand_config();
      idle_on = (phase % 3 != 2);
      start = bases_sent;
      while (bases_sent - start < 10) begin
        hq = ($urandom_range(0, 99) < 80);
        send_read(pick_len(), $urandom_range(0, 3), hq, $urandom_range(0, 99) < 20);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_index              <= CFG_HEAD_CROP;
    cfg_data               <= '0;
    base_ch.valid          <= 1'b0;
    base_ch.qual_char      <= '0;
    base_ch.has_quality    <= 1'b0;
    base_ch.last_base      <= 1'b0;
    for (int q = 0; q < TABLE_SIZE; q++) err_prob[q] = err_entry(q);
    cfg_head   = '0;
    cfg_tail   = '0;
    cfg_min    = LEN_W'(1);
    cfg_maxp   = PROB_ONE;
    run_pos    = '0;
    run_total  = '0;
    run_middle = '0;
    ring_ptr   = '0;
    idle_on    = 1'b1;
    bases_sent = 0;
    reads_sent = 0;
    verdicts_checked = 0;
    config_count = 0;
    mismatches = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_score_clamp();
    test_crop_edges();
    test_config_extremes();
    test_random_reads();

    settle();
    repeat (12) @(posedge clk);
    $display("Covered %0d bases in %0d reads, %0d verdicts checked, %0d register settings.",
             bases_sent, reads_sent, verdicts_checked, config_count);
    $display("Score clamping, crop and register extremes and reads without qualities exercised.");
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("read_quality_crop_filter regression: pass");
    end else begin
      $display("read_quality_crop_filter regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rqcf_pkg.sv
rtl/rqcf_if.sv
rtl/rqcf_front.sv
rtl/rqcf_accum.sv
rtl/rqcf_judge.sv
rtl/read_quality_crop_filter.sv
rtl/rqcf_checker.sv
sim/tb_top.sv
